>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Every check is sampled on
// the rising edge of clk and is switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/skts_pkg.sv
// ----------------------------------------------------------------------------
// skts_pkg
// Shared constants and types for the sorted keyword table search block.
// ----------------------------------------------------------------------------
package skts_pkg;

	// Default table geometry
	localparam int DEF_TABLE_DEPTH = 512;
	localparam int DEF_KEY_BYTES   = 20;
	localparam int DEF_CODE_BITS   = 10;

	// Fixed port widths
	localparam int IN_KEY_BYTES = 20;
	localparam int IN_KEY_BITS  = IN_KEY_BYTES * 8;
	localparam int COUNT_BITS   = 10;
	localparam int INDEX_BITS   = 9;
	localparam int PORT_CODE_BITS = 10;

	// Request operation codes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// Search sequencer states
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_PROBE = 3'b010,
		ST_DONE  = 3'b100
	} state_t;

endpackage

>>> rtl/core/sorted_keyword_table_search.sv
// ----------------------------------------------------------------------------
// sorted_keyword_table_search
// Keyword table with binary-search lookup. Requests arrive on in_valid /
// in_ready. A load request (operation = load) writes one slot, key and code,
// and produces no result. A lookup request searches the first entry_count
// slots, which must be loaded in ascending key order, and returns found and
// command_code on out_valid / out_ready. Keys compare like strcmp on bytes.
// entry_count is written through cfg_we / cfg_wdata; the user must write it
// only while the block is idle, which the block does not enforce. A load
// writes its slot and leaves the block idle. A lookup runs one probe per cycle
// on the key memory (registered read), at most floor(log2(entry_count)) + 1
// probes, then waits in ST_DONE for a free output register; out_valid and
// in_ready then rise together, and no request is taken while a lookup runs.
// A new request is taken while a result still waits in the output register;
// a lookup that finishes while the receiver stalls holds until it is free.
// Reset clears entry_count and the control state; the table contents are
// undefined until loaded, and no clearing pass is run.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_keyword_table_search #(
	parameter int TABLE_DEPTH = skts_pkg::DEF_TABLE_DEPTH,
	parameter int KEY_BYTES   = skts_pkg::DEF_KEY_BYTES,
	parameter int CODE_BITS   = skts_pkg::DEF_CODE_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_we,
	input  logic [skts_pkg::COUNT_BITS-1:0]       cfg_wdata,
	// request channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  operation,
	input  logic [skts_pkg::INDEX_BITS-1:0]       entry_index,
	input  logic [63:0]                           key_upper,
	input  logic [63:0]                           key_middle,
	input  logic [31:0]                           key_lower,
	input  logic [skts_pkg::PORT_CODE_BITS-1:0]   entry_code,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  found,
	output logic [skts_pkg::PORT_CODE_BITS-1:0]   command_code
);

	localparam int KEY_W = KEY_BYTES * 8;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// Storage
	logic [KEY_W-1:0]     key_mem  [TABLE_DEPTH];
	logic [CODE_BITS-1:0] code_mem [TABLE_DEPTH];
	logic [KEY_W-1:0]     rd_key_q;
	logic [CODE_BITS-1:0] rd_code_q;

	// Control and payload registers
	skts_pkg::state_t                  state_q;
	logic [skts_pkg::COUNT_BITS-1:0]   entry_count_q;
	logic [KEY_W-1:0]                  key_q;
	logic [CNT_W-1:0]                  lo_q;
	logic [CNT_W-1:0]                  he_q;
	logic [IDX_W-1:0]                  mid_q;
	logic                              res_found_q;
	logic [skts_pkg::PORT_CODE_BITS-1:0] res_code_q;
	logic                              out_valid_q;
	logic                              found_q;
	logic [skts_pkg::PORT_CODE_BITS-1:0] command_code_q;

	// Combinational
	logic [skts_pkg::IN_KEY_BITS-1:0]  in_key;
	logic [skts_pkg::IN_KEY_BYTES-1:0] byte_nz;
	logic [skts_pkg::IN_KEY_BYTES-1:0] byte_keep;
	logic [KEY_W-1:0]                  key_norm;
	logic                              in_acc;
	logic                              mem_we;
	logic [IDX_W-1:0]                  wr_addr;
	logic [31:0]                       count_wide;
	logic [CNT_W-1:0]                  count_sat;
	logic [CNT_W:0]                    mid0_sum;
	logic [IDX_W-1:0]                  mid0;
	logic                              cmp_eq;
	logic                              cmp_gt;
	logic [CNT_W-1:0]                  lo_nx;
	logic [CNT_W-1:0]                  he_nx;
	logic [CNT_W:0]                    mid_sum;
	logic [IDX_W-1:0]                  mid_nx;
	logic                              probe_miss;
	logic [IDX_W-1:0]                  rd_addr;
	logic                              out_free;
	logic [31:0]                       code_in_wide;
	logic [31:0]                       code_rd_wide;

	assign in_key   = {key_upper, key_middle, key_lower};
	assign in_ready = (state_q == skts_pkg::ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Key normalize: zero every byte after the first zero byte, so that a
	// plain unsigned compare of the whole word gives strcmp order
	always_comb begin
		for (int i = 0; i < skts_pkg::IN_KEY_BYTES; i++) begin
			byte_nz[i] = (in_key[skts_pkg::IN_KEY_BITS-1-8*i -: 8] != 8'd0);
		end
		for (int i = 0; i < skts_pkg::IN_KEY_BYTES; i++) begin
			byte_keep[i] = &(byte_nz | ~((skts_pkg::IN_KEY_BYTES'(1) << i)
				- skts_pkg::IN_KEY_BYTES'(1)));
		end
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (i < skts_pkg::IN_KEY_BYTES) begin
				key_norm[KEY_W-1-8*i -: 8] =
					byte_keep[i] ? in_key[skts_pkg::IN_KEY_BITS-1-8*i -: 8] : 8'd0;
			end else begin
				key_norm[KEY_W-1-8*i -: 8] = 8'd0;
			end
		end
	end

	// Load write port; slots past the table are dropped
	assign code_in_wide = 32'(entry_code);
	assign wr_addr      = IDX_W'(32'(entry_index));
	assign mem_we       = in_acc && (operation == skts_pkg::OP_LOAD) &&
		(32'(entry_index) < 32'(TABLE_DEPTH));

	// First probe: count saturated to the depth, middle of [0, count)
	assign count_wide = (32'(entry_count_q) > 32'(TABLE_DEPTH)) ?
		32'(TABLE_DEPTH) : 32'(entry_count_q);
	assign count_sat  = count_wide[CNT_W-1:0];
	assign mid0_sum   = (CNT_W+1)'(count_sat) - (CNT_W+1)'(1);
	assign mid0       = mid0_sum[IDX_W:1];

	// Probe step: compare against the slot read last cycle, narrow the
	// half-open range [lo, he) and pick the next middle
	assign cmp_eq = (key_q == rd_key_q);
	assign cmp_gt = (key_q > rd_key_q);

	always_comb begin
		lo_nx = lo_q;
		he_nx = he_q;
		if (cmp_gt) begin
			lo_nx = CNT_W'(mid_q) + CNT_W'(1);
		end else begin
			he_nx = CNT_W'(mid_q);
		end
	end

	assign probe_miss = (lo_nx >= he_nx);
	assign mid_sum    = (CNT_W+1)'(lo_nx) + (CNT_W+1)'(he_nx) - (CNT_W+1)'(1);
	assign mid_nx     = mid_sum[IDX_W:1];
	assign rd_addr    = (state_q == skts_pkg::ST_IDLE) ? mid0 : mid_nx;

	assign code_rd_wide = 32'(rd_code_q);

	// Table memories, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[wr_addr]  <= key_norm;
			code_mem[wr_addr] <= code_in_wide[CODE_BITS-1:0];
		end
		rd_key_q  <= key_mem[rd_addr];
		rd_code_q <= code_mem[rd_addr];
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	// Search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skts_pkg::ST_IDLE;
			lo_q    <= '0;
			he_q    <= '0;
		end else begin
			unique case (state_q)
				skts_pkg::ST_IDLE: begin
					if (in_acc && (operation == skts_pkg::OP_LOOKUP)) begin
						lo_q <= '0;
						he_q <= count_sat;
						if (count_sat == '0) begin
							state_q <= skts_pkg::ST_DONE;
						end else begin
							state_q <= skts_pkg::ST_PROBE;
						end
					end
				end
				skts_pkg::ST_PROBE: begin
					if (cmp_eq) begin
						lo_q    <= CNT_W'(mid_q);
						he_q    <= CNT_W'(mid_q) + CNT_W'(1);
						state_q <= skts_pkg::ST_DONE;
					end else begin
						lo_q <= lo_nx;
						he_q <= he_nx;
						if (probe_miss) begin
							state_q <= skts_pkg::ST_DONE;
						end
					end
				end
				skts_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= skts_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= skts_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Search payload: key, probe address and pending result
	always_ff @(posedge clk) begin
		if (state_q != skts_pkg::ST_DONE) begin
			mid_q <= rd_addr;
		end
		if (in_acc) begin
			key_q       <= key_norm;
			res_found_q <= 1'b0;
			res_code_q  <= '0;
		end else if ((state_q == skts_pkg::ST_PROBE) && cmp_eq) begin
			res_found_q <= 1'b1;
			res_code_q  <= code_rd_wide[skts_pkg::PORT_CODE_BITS-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == skts_pkg::ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == skts_pkg::ST_DONE) && out_free) begin
			found_q        <= res_found_q;
			command_code_q <= res_code_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign command_code = command_code_q;

	// Checks
	`ASSERT_SAME(a_probe_range, state_q == skts_pkg::ST_PROBE,
		(lo_q < he_q) && (32'(he_q) <= 32'(TABLE_DEPTH)), "probe with empty or oversized range")
	`ASSERT_SAME(a_probe_mid, state_q == skts_pkg::ST_PROBE,
		(CNT_W'(mid_q) >= lo_q) && (CNT_W'(mid_q) < he_q), "probe address outside range")
	`ASSERT_NEXT(a_lookup_starts, in_acc && (operation == skts_pkg::OP_LOOKUP),
		state_q != skts_pkg::ST_IDLE, "lookup request did not start a search")
	`ASSERT_SAME(a_miss_code, out_valid_q && !found_q,
		command_code_q == '0, "miss result carries a nonzero code")

endmodule
